// ===== sv/queued_lock_manager_defines.svh =====
// assertion macros for the queued lock manager
`ifndef QUEUED_LOCK_MANAGER_DEFINES_SVH
`define QUEUED_LOCK_MANAGER_DEFINES_SVH

// same-cycle implication under reset
`define QLM_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under reset
`define QLM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/qlm_pkg.sv =====
// shared constants for the queued lock manager
package qlm_pkg;

    localparam int NUM_LOCKS_DEF  = 16;
    localparam int WAIT_DEPTH_DEF = 8;
    localparam int ID_BITS_DEF    = 8;

    localparam logic [1:0] ACT_LOCK   = 2'd0;
    localparam logic [1:0] ACT_UNLOCK = 2'd1;
    localparam logic [1:0] ACT_CANCEL = 2'd2;
    localparam logic [1:0] ACT_QUERY  = 2'd3;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND   = 3'd1;
    localparam logic [2:0] ST_RECURSIVE   = 3'd2;
    localparam logic [2:0] ST_PENDING     = 3'd3;
    localparam logic [2:0] ST_HELD_OTHERS = 3'd4;
    localparam logic [2:0] ST_QUEUE_FULL  = 3'd5;

endpackage

// ===== sv/qlm_ram.sv =====
// generic single-write, single-read ram with registered read
module qlm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/queued_lock_manager.sv =====
// Queued lock manager: a table of NUM_LOCKS lock entries with a FIFO of up to
// WAIT_DEPTH waiters each. After reset the block sweeps the entry table,
// clearing every entry, and takes no request meanwhile. A request then goes
// through S_READ, S_EXEC, S_COMMIT and S_EMIT to its first result for lock,
// query and most unlocks; an unlock that hands over, or a cancel on a non-empty
// queue, walks the waiter FIFO through the waiter memory's single read port,
// one S_WRD/S_WWAIT pass per slot. One request is in work at a time; an unlock
// with handover gives two results, an ack and then a grant marked in m_tuser.
`include "queued_lock_manager_defines.svh"

module queued_lock_manager #(
    parameter int NUM_LOCKS  = qlm_pkg::NUM_LOCKS_DEF,
    parameter int WAIT_DEPTH = qlm_pkg::WAIT_DEPTH_DEF,
    parameter int ID_BITS    = qlm_pkg::ID_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // lock_number[3:0], requester[11:4], create_if_missing[12]
    input  logic [1:0]  s_tuser,   // action[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // status[2:0], owner_valid[3], owner[11:4], version[43:12]
    output logic [0:0]  m_tuser,   // is_grant[0]
    output logic        m_tlast
);

    localparam int LOCK_W = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;
    localparam int CNT_W  = $clog2(WAIT_DEPTH + 1);
    localparam int SLOT_W = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
    localparam int WDEPTH = NUM_LOCKS * WAIT_DEPTH;
    localparam int WA_W   = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;

    typedef struct packed {
        logic               exists;
        logic               held;
        logic [ID_BITS-1:0] holder;
        logic [31:0]        version;
        logic [CNT_W-1:0]   count;
    } entry_t;

    localparam int ENT_W = $bits(entry_t);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_READ, S_EXEC, S_WRD, S_WWAIT, S_COMMIT, S_EMIT, S_EMIT2
    } state_t;

    typedef enum logic [1:0] {M_POP, M_SCAN, M_SHIFT} mode_t;

    state_t             state_reg;
    mode_t              mode_reg;
    logic [LOCK_W-1:0]  clr_reg;
    logic [LOCK_W-1:0]  idx_reg;
    logic               oor_reg;
    logic [1:0]         act_reg;
    logic [ID_BITS-1:0] req_reg;
    logic               create_reg;
    entry_t             ent_reg;
    logic               dirty_reg;
    logic               two_reg;
    logic [2:0]         status_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   ptr_reg;

    logic               m_tvalid_reg;
    logic [47:0]        m_tdata_reg;
    logic               m_tuser_reg;
    logic               m_tlast_reg;

    logic               e_we;
    logic [LOCK_W-1:0]  e_waddr;
    logic [LOCK_W-1:0]  e_raddr;
    logic [ENT_W-1:0]   e_wdata;
    logic [ENT_W-1:0]   e_rdata;
    entry_t             e_rd;

    logic               w_we;
    logic [WA_W-1:0]    w_waddr;
    logic [WA_W-1:0]    w_raddr;
    logic [ID_BITS-1:0] w_rdata;
    logic [WA_W-1:0]    w_base;
    logic               nf;
    logic               pend_case;
    logic               out_free;
    logic [47:0]        res_data;

    assign e_rd     = entry_t'(e_rdata);
    assign nf       = oor_reg || !ent_reg.exists;
    assign pend_case = (state_reg == S_EXEC) && !nf && (act_reg == qlm_pkg::ACT_LOCK)
                     && ent_reg.held && (ent_reg.holder != req_reg)
                     && (ent_reg.count < CNT_W'(WAIT_DEPTH));
    assign w_base   = WA_W'(idx_reg) * WA_W'(WAIT_DEPTH);
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        e_raddr = (state_reg == S_IDLE) ? LOCK_W'(s_tdata[3:0]) : idx_reg;
        e_we    = (state_reg == S_CLEAR) || ((state_reg == S_COMMIT) && dirty_reg);
        e_waddr = (state_reg == S_CLEAR) ? clr_reg : idx_reg;
        e_wdata = (state_reg == S_CLEAR) ? '0 : ENT_W'(ent_reg);
        w_raddr = w_base + WA_W'(ptr_reg[SLOT_W-1:0]);
        w_we    = pend_case || ((state_reg == S_WWAIT) && (mode_reg == M_SHIFT));
        w_waddr = pend_case ? (w_base + WA_W'(ent_reg.count[SLOT_W-1:0]))
                            : (w_base + WA_W'(ptr_reg[SLOT_W-1:0] - SLOT_W'(1)));
        res_data = '0;
        res_data[2:0]   = status_reg;
        res_data[3]     = ent_reg.held;
        res_data[11:4]  = ent_reg.held ? 8'(ent_reg.holder) : 8'd0;
        res_data[43:12] = ent_reg.version;
    end

    qlm_ram #(.WIDTH(ENT_W), .DEPTH(NUM_LOCKS)) u_entry_ram (
        .aclk  (aclk),
        .we    (e_we),
        .waddr (e_waddr),
        .wdata (e_wdata),
        .raddr (e_raddr),
        .rdata (e_rdata)
    );

    qlm_ram #(.WIDTH(ID_BITS), .DEPTH(WDEPTH)) u_waiter_ram (
        .aclk  (aclk),
        .we    (w_we),
        .waddr (w_waddr),
        .wdata (pend_case ? req_reg : w_rdata),
        .raddr (w_raddr),
        .rdata (w_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            mode_reg     <= M_POP;
            dirty_reg    <= 1'b0;
            two_reg      <= 1'b0;
        end else begin
            if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR: begin
                    clr_reg <= clr_reg + LOCK_W'(1);
                    if (clr_reg == LOCK_W'(NUM_LOCKS - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_tvalid) begin
                        idx_reg    <= LOCK_W'(s_tdata[3:0]);
                        oor_reg    <= 32'(s_tdata[3:0]) >= NUM_LOCKS;
                        req_reg    <= ID_BITS'(s_tdata[11:4]);
                        create_reg <= s_tdata[12];
                        act_reg    <= s_tuser;
                        dirty_reg  <= 1'b0;
                        two_reg    <= 1'b0;
                        state_reg  <= S_READ;
                    end
                end
                S_READ: begin
                    ent_reg   <= e_rd;
                    state_reg <= S_EXEC;
                end
                S_EXEC: begin
                    cnt_reg   <= ent_reg.count;
                    ptr_reg   <= '0;
                    state_reg <= S_COMMIT;
                    if (nf) begin
                        if (act_reg == qlm_pkg::ACT_LOCK && create_reg && !oor_reg) begin
                            ent_reg.exists  <= 1'b1;
                            ent_reg.held    <= 1'b1;
                            ent_reg.holder  <= req_reg;
                            ent_reg.version <= 32'd1;
                            ent_reg.count   <= '0;
                            dirty_reg       <= 1'b1;
                            status_reg      <= qlm_pkg::ST_OK;
                        end else begin
                            ent_reg    <= '0;
                            status_reg <= qlm_pkg::ST_NOT_FOUND;
                        end
                    end else begin
                        case (act_reg)
                            qlm_pkg::ACT_LOCK: begin
                                if (!ent_reg.held) begin
                                    ent_reg.held    <= 1'b1;
                                    ent_reg.holder  <= req_reg;
                                    ent_reg.version <= ent_reg.version + 32'd1;
                                    dirty_reg       <= 1'b1;
                                    status_reg      <= qlm_pkg::ST_OK;
                                end else if (ent_reg.holder == req_reg) begin
                                    status_reg <= qlm_pkg::ST_RECURSIVE;
                                end else if (!pend_case) begin
                                    status_reg <= qlm_pkg::ST_QUEUE_FULL;
                                end else begin
                                    ent_reg.count <= ent_reg.count + CNT_W'(1);
                                    dirty_reg     <= 1'b1;
                                    status_reg    <= qlm_pkg::ST_PENDING;
                                end
                            end
                            qlm_pkg::ACT_UNLOCK: begin
                                if (!ent_reg.held || ent_reg.holder != req_reg) begin
                                    status_reg <= qlm_pkg::ST_HELD_OTHERS;
                                end else begin
                                    ent_reg.version <= ent_reg.version + 32'd1;
                                    dirty_reg       <= 1'b1;
                                    status_reg      <= qlm_pkg::ST_OK;
                                    if (ent_reg.count != '0) begin
                                        two_reg   <= 1'b1;
                                        mode_reg  <= M_POP;
                                        state_reg <= S_WRD;
                                    end else begin
                                        ent_reg.held   <= 1'b0;
                                        ent_reg.holder <= '0;
                                    end
                                end
                            end
                            qlm_pkg::ACT_CANCEL: begin
                                status_reg <= qlm_pkg::ST_NOT_FOUND;
                                if (ent_reg.count != '0) begin
                                    mode_reg  <= M_SCAN;
                                    state_reg <= S_WRD;
                                end
                            end
                            default: begin
                                status_reg <= qlm_pkg::ST_OK;
                            end
                        endcase
                    end
                end
                S_WRD: begin
                    state_reg <= S_WWAIT;
                end
                S_WWAIT: begin
                    state_reg <= S_COMMIT;
                    case (mode_reg)
                        M_POP: begin
                            ent_reg.holder <= w_rdata;
                            ent_reg.count  <= ent_reg.count - CNT_W'(1);
                            if (cnt_reg > CNT_W'(1)) begin
                                ptr_reg   <= CNT_W'(1);
                                mode_reg  <= M_SHIFT;
                                state_reg <= S_WRD;
                            end
                        end
                        M_SCAN: begin
                            if (w_rdata == req_reg) begin
                                ent_reg.count <= ent_reg.count - CNT_W'(1);
                                dirty_reg     <= 1'b1;
                                status_reg    <= qlm_pkg::ST_OK;
                                mode_reg      <= M_SHIFT;
                            end
                            if (ptr_reg + CNT_W'(1) < cnt_reg) begin
                                ptr_reg   <= ptr_reg + CNT_W'(1);
                                state_reg <= S_WRD;
                            end
                        end
                        default: begin
                            if (ptr_reg + CNT_W'(1) < cnt_reg) begin
                                ptr_reg   <= ptr_reg + CNT_W'(1);
                                state_reg <= S_WRD;
                            end
                        end
                    endcase
                end
                S_COMMIT: begin
                    state_reg <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= res_data;
                        m_tuser_reg  <= 1'b0;
                        m_tlast_reg  <= !two_reg;
                        state_reg    <= two_reg ? S_EMIT2 : S_IDLE;
                    end
                end
                S_EMIT2: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= res_data;
                        m_tuser_reg  <= 1'b1;
                        m_tlast_reg  <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready   = (state_reg == S_IDLE);
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;
    assign m_tlast    = m_tlast_reg;

    `QLM_ASSERT_NOW(a_grant_last, aclk, aresetn, m_tvalid && m_tuser[0], m_tlast, "grant not final")
    `QLM_ASSERT_NOW(a_clear_quiet, aclk, aresetn, state_reg == S_CLEAR, !w_we && !s_tready, "activity during clear")
    `QLM_ASSERT_NEXT(a_one_request, aclk, aresetn, s_tvalid && s_tready, !s_tready, "second request taken")

endmodule
